[rtl/tli_pkg.sv]
`timescale 1ns / 1ps
// Package for the letter trie: operation codes, walker states, result type.
// No dependencies.
package tli_pkg;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_PREFIX = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_END_RD,
    S_END
  } walk_state_e;

  typedef struct packed {
    logic pool_full;
    logic found;
  } result_t;

endpackage

[rtl/tli_row_ram.sv]
`timescale 1ns / 1ps
// Simple dual-port RAM, one write and one read port, registered read data.
// No dependencies.
module tli_row_ram #(
  parameter int WIDTH = 261,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tli_walk.sv]
`timescale 1ns / 1ps
// Trie walker: clears the node table, follows and allocates child links,
// marks and tests word ends. Uses tli_pkg and tli_row_ram.
module tli_walk #(
  parameter int NODES    = 1024,
  parameter int ALPHABET = 26
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       in_kind_i,
  input  logic [4:0]       in_letter_i,
  input  logic             in_no_letter_i,
  input  logic             in_last_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output tli_pkg::result_t res_o
);

  localparam int IW = $clog2(NODES);
  localparam int CW = IW + 1;
  localparam int LW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int RW = ALPHABET * IW + 1;

  tli_pkg::walk_state_e state_q, state_d;
  logic [IW-1:0] cursor_q, cursor_d;
  logic [CW-1:0] used_q, used_d;
  logic [IW-1:0] clr_q, clr_d;
  logic          broken_q, broken_d;
  logic          ovf_q, ovf_d;
  logic [1:0]    kind_q, kind_d;
  logic [LW-1:0] let_q, let_d;
  logic          last_q, last_d;

  logic          we, re;
  logic [IW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rd_row, row_link, row_end;
  logic [IW-1:0] link;
  logic          skip, oor, ok;

  tli_row_ram #(.WIDTH(RW), .DEPTH(NODES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_row)
  );

  assign oor   = 32'(in_letter_i) >= 32'(ALPHABET);
  assign skip  = in_no_letter_i || broken_q || ovf_q || oor;
  assign link  = rd_row[let_q*IW +: IW];
  assign ok    = !broken_q && !ovf_q;

  always_comb begin
    row_link = rd_row;
    row_link[let_q*IW +: IW] = used_q[IW-1:0];
    row_end = rd_row;
    row_end[RW-1] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tli_pkg::S_CLEAR;
      cursor_q <= '0;
      used_q   <= CW'(1);
      clr_q    <= '0;
      broken_q <= 1'b0;
      ovf_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      used_q   <= used_d;
      clr_q    <= clr_d;
      broken_q <= broken_d;
      ovf_q    <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    let_q  <= let_d;
    last_q <= last_d;
  end

  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    used_d      = used_q;
    clr_d       = clr_q;
    broken_d    = broken_q;
    ovf_d       = ovf_q;
    kind_d      = kind_q;
    let_d       = let_q;
    last_d      = last_q;
    we          = 1'b0;
    waddr       = cursor_q;
    wdata       = row_link;
    re          = 1'b0;
    raddr       = cursor_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (state_q)
      tli_pkg::S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == IW'(NODES - 1)) begin
          state_d = tli_pkg::S_IDLE;
        end
      end
      tli_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          re     = 1'b1;
          kind_d = in_kind_i;
          let_d  = LW'(in_letter_i);
          last_d = in_last_i;
          if (!in_no_letter_i && !broken_q && !ovf_q && oor) begin
            broken_d = 1'b1;
          end
          if (!skip) begin
            state_d = tli_pkg::S_WALK;
          end else if (in_last_i) begin
            state_d = tli_pkg::S_END;
          end
        end
      end
      tli_pkg::S_WALK: begin
        if (link != '0) begin
          cursor_d = link;
        end else if (kind_q != tli_pkg::KIND_INSERT) begin
          broken_d = 1'b1;
        end else if (used_q >= CW'(NODES)) begin
          ovf_d = 1'b1;
        end else begin
          we       = 1'b1;
          cursor_d = used_q[IW-1:0];
          used_d   = used_q + 1'b1;
        end
        state_d = last_q ? tli_pkg::S_END_RD : tli_pkg::S_IDLE;
      end
      tli_pkg::S_END_RD: begin
        re      = 1'b1;
        state_d = tli_pkg::S_END;
      end
      tli_pkg::S_END: begin
        res_valid_o = 1'b1;
        case (kind_q)
          tli_pkg::KIND_INSERT: begin
            res_o.found     = ok;
            res_o.pool_full = ovf_q;
          end
          tli_pkg::KIND_SEARCH: res_o.found = ok && rd_row[RW-1];
          default:              res_o.found = ok;
        endcase
        if (res_ready_i) begin
          if (kind_q == tli_pkg::KIND_INSERT && ok) begin
            we    = 1'b1;
            wdata = row_end;
          end
          cursor_d = '0;
          broken_d = 1'b0;
          ovf_d    = 1'b0;
          state_d  = tli_pkg::S_IDLE;
        end
      end
      default: state_d = tli_pkg::S_IDLE;
    endcase
  end

endmodule

[rtl/trie_insert_lookup.sv]
`timescale 1ns / 1ps
// Channel | dir | tdata                      | tuser                  | tlast
// s_axis  | in  | letter[4:0], zero [7:5]    | kind[1:0], no_letter[2]| last of word
// m_axis  | out | found[0], pool_full[1]     | -                      | -
//
// A letter item's transaction reads the node row, then S_WALK follows or
// allocates the child link. A last item reads the end node in S_END_RD and,
// on insert, writes its word-end bit in S_END. With no walk an item stays
// idle, or goes to S_END if last. After reset the table is swept clear, one
// row a cycle, with s_axis_tready low. A stalled m_axis holds the walker in
// its end state. Top level of the letter trie; uses tli_pkg and tli_walk.
module trie_insert_lookup #(
  parameter int NODES    = 1024,
  parameter int ALPHABET = 26
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // letter[4:0], zero pad [7:5]
  input  logic [2:0] s_axis_tuser_i,   // kind[1:0], no_letter[2]
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // found[0], pool_full[1], zero pad [7:2]
);

  logic             res_valid, res_ready;
  tli_pkg::result_t res, out_q;
  logic             out_valid_q, out_valid_d;

  tli_walk #(.NODES(NODES), .ALPHABET(ALPHABET)) u_walk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .in_kind_i      (s_axis_tuser_i[1:0]),
    .in_letter_i    (s_axis_tdata_i[4:0]),
    .in_no_letter_i (s_axis_tuser_i[2]),
    .in_last_i      (s_axis_tlast_i),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_q.pool_full, out_q.found};

  a_full_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tdata_o[1]))
    else $error("pool_full reported together with found");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i) |=> !s_axis_tready_o)
    else $error("walker ready right after last-of-word transaction");

  a_result_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !s_axis_tready_o)
    else $error("input taken while a result is pending in the walker");

endmodule
